/* hdl/lrcts_pkg.sv */
// Shared types and constants of the LRC time-tag parser.
package lrcts_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_OPEN,
    PH_MIN,
    PH_SEC,
    PH_FRAC
  } phase_t;

  typedef struct packed {
    logic malformed;
    logic table_full;
  } tag_flags_t;

  localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
  localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
  localparam logic [7:0] CHAR_COLON    = 8'h3A;
  localparam logic [7:0] CHAR_DOT      = 8'h2E;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_NINE     = 8'h39;

  localparam int TIME_W  = 26;
  localparam int INDEX_W = 8;

  localparam int MS_PER_MIN = 60000;
  localparam int MS_PER_SEC = 1000;
  localparam int MS_PER_TENTH = 100;
  localparam int MS_PER_HUNDREDTH = 10;

  // floor(x/10) == (x*6554) >> 16 for every x below 16384
  localparam int DIV10_RECIP = 6554;
  localparam int DIV10_SHIFT = 16;

endpackage

/* hdl/lrc_timestamp_tag_parser_top.sv */
// LRC time-tag parser: takes one text byte per cycle, gives one result per closed tag.
// Throughput: one byte per cycle while results are taken; the phase machine updates per byte.
// After the edge that accepts the closing ']', a tag passes the capture, product and sum
// stages of the time pipeline before out_valid rises.
// Reset: synchronous rst clears the parser, the entry count and all stage valids.
// new_file with a byte clears the parser and entry count before that byte is parsed.
module lrc_timestamp_tag_parser_top #(
  parameter int TABLE_ENTRIES = 256,
  parameter int FIELD_DIGITS  = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    text_byte,
  input  logic                          new_file,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lrcts_pkg::TIME_W-1:0]  time_ms,
  output logic [lrcts_pkg::INDEX_W-1:0] entry_index,
  output logic                          malformed,
  output logic                          table_full
);
  import lrcts_pkg::*;

  localparam int ACC_W = $clog2(10 ** FIELD_DIGITS);
  localparam int CNT_W = $clog2(FIELD_DIGITS + 1);

  logic               accept;
  logic               emit;
  logic [ACC_W-1:0]   tag_min, tag_sec, tag_frac;
  logic [CNT_W-1:0]   tag_fdig;
  tag_flags_t         tag_flags, res_flags;
  logic [INDEX_W-1:0] tag_idx;

  assign accept = in_valid && in_ready;

  lrcts_parser #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .FIELD_DIGITS (FIELD_DIGITS),
    .ACC_W        (ACC_W),
    .CNT_W        (CNT_W)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .text_byte  (text_byte),
    .new_file   (new_file),
    .emit       (emit),
    .minutes    (tag_min),
    .seconds    (tag_sec),
    .fraction   (tag_frac),
    .frac_digits(tag_fdig),
    .flags      (tag_flags),
    .entry_index(tag_idx)
  );

  lrcts_time_calc #(
    .FIELD_DIGITS(FIELD_DIGITS),
    .ACC_W       (ACC_W),
    .CNT_W       (CNT_W)
  ) u_time_calc (
    .clk        (clk),
    .rst        (rst),
    .tag_valid  (accept && emit),
    .tag_ready  (in_ready),
    .minutes    (tag_min),
    .seconds    (tag_sec),
    .fraction   (tag_frac),
    .frac_digits(tag_fdig),
    .flags      (tag_flags),
    .entry_index(tag_idx),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .time_ms    (time_ms),
    .out_index  (entry_index),
    .out_flags  (res_flags)
  );

  assign malformed  = res_flags.malformed;
  assign table_full = res_flags.table_full;

endmodule

/* hdl/lrcts_parser.sv */
// Byte-level tag parser: phase machine, field accumulators and entry counter.
module lrcts_parser #(
  parameter int TABLE_ENTRIES = 256,
  parameter int FIELD_DIGITS  = 3,
  parameter int ACC_W         = $clog2(10 ** FIELD_DIGITS),
  parameter int CNT_W         = $clog2(FIELD_DIGITS + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [7:0]                text_byte,
  input  logic                      new_file,
  output logic                      emit,
  output logic [ACC_W-1:0]          minutes,
  output logic [ACC_W-1:0]          seconds,
  output logic [ACC_W-1:0]          fraction,
  output logic [CNT_W-1:0]          frac_digits,
  output lrcts_pkg::tag_flags_t     flags,
  output logic [lrcts_pkg::INDEX_W-1:0] entry_index
);
  import lrcts_pkg::*;

  localparam int ENT_W = $clog2(TABLE_ENTRIES + 1);

  phase_t             phase, phase_next, phase_cur;
  logic [ACC_W-1:0]   minutes_acc, minutes_acc_next, min_cur;
  logic [ACC_W-1:0]   seconds_acc, seconds_acc_next, sec_cur;
  logic [ACC_W-1:0]   fraction_acc, fraction_acc_next, frac_cur;
  logic [CNT_W-1:0]   digit_count, digit_count_next, cnt_cur;
  logic               bad_tag, bad_tag_next, bad_cur;
  logic [ENT_W-1:0]   entry_count, entry_count_next, entry_cur;

  logic               is_numeral;
  logic               is_close;
  logic [ACC_W-1:0]   digit_val;
  logic               can_take;
  logic               full;

  assign is_numeral = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
  assign is_close   = (text_byte == CHAR_RBRACKET);
  assign digit_val  = ACC_W'(4'(text_byte - CHAR_ZERO));

  // new_file clears everything before the byte itself is parsed
  assign phase_cur = new_file ? PH_IDLE : phase;
  assign min_cur   = new_file ? '0 : minutes_acc;
  assign sec_cur   = new_file ? '0 : seconds_acc;
  assign frac_cur  = new_file ? '0 : fraction_acc;
  assign cnt_cur   = new_file ? '0 : digit_count;
  assign bad_cur   = new_file ? 1'b0 : bad_tag;
  assign entry_cur = new_file ? '0 : entry_count;

  assign can_take = (cnt_cur < CNT_W'(FIELD_DIGITS));
  assign full     = (entry_cur >= ENT_W'(TABLE_ENTRIES));

  // next phase
  always_comb begin
    phase_next = phase_cur;
    case (phase_cur)
      PH_IDLE: begin
        if (text_byte == CHAR_LBRACKET) phase_next = PH_OPEN;
      end
      PH_OPEN: begin
        if (is_numeral) phase_next = PH_MIN;
        else if (text_byte != CHAR_LBRACKET) phase_next = PH_IDLE;
      end
      PH_MIN: begin
        if (is_close) phase_next = PH_IDLE;
        else if (text_byte == CHAR_COLON) phase_next = PH_SEC;
      end
      PH_SEC: begin
        if (is_close) phase_next = PH_IDLE;
        else if (text_byte == CHAR_DOT) phase_next = PH_FRAC;
      end
      PH_FRAC: begin
        if (is_close) phase_next = PH_IDLE;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // accumulators, flags, counter and tag emission
  always_comb begin
    minutes_acc_next  = min_cur;
    seconds_acc_next  = sec_cur;
    fraction_acc_next = frac_cur;
    digit_count_next  = cnt_cur;
    bad_tag_next      = bad_cur;
    entry_count_next  = entry_cur;
    emit              = 1'b0;
    case (phase_cur)
      PH_OPEN: begin
        if (is_numeral) begin
          minutes_acc_next  = digit_val;
          seconds_acc_next  = '0;
          fraction_acc_next = '0;
          digit_count_next  = CNT_W'(1);
          bad_tag_next      = 1'b0;
        end
      end
      PH_MIN, PH_SEC, PH_FRAC: begin
        if (is_close) begin
          emit              = 1'b1;
          minutes_acc_next  = '0;
          seconds_acc_next  = '0;
          fraction_acc_next = '0;
          digit_count_next  = '0;
          bad_tag_next      = 1'b0;
          if (!full) entry_count_next = entry_cur + ENT_W'(1);
        end else if (is_numeral) begin
          if (can_take) begin
            digit_count_next = cnt_cur + CNT_W'(1);
            case (phase_cur)
              PH_MIN:  minutes_acc_next  = min_cur * ACC_W'(10) + digit_val;
              PH_SEC:  seconds_acc_next  = sec_cur * ACC_W'(10) + digit_val;
              default: fraction_acc_next = frac_cur * ACC_W'(10) + digit_val;
            endcase
          end else begin
            // excess digit: flag and drop
            bad_tag_next = 1'b1;
          end
        end else if (phase_cur == PH_MIN && text_byte == CHAR_COLON) begin
          digit_count_next = '0;
        end else if (phase_cur == PH_SEC && text_byte == CHAR_DOT) begin
          digit_count_next = '0;
        end else begin
          bad_tag_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign minutes          = min_cur;
  assign seconds          = sec_cur;
  assign fraction         = frac_cur;
  assign frac_digits      = (phase_cur == PH_FRAC) ? cnt_cur : '0;
  assign flags.malformed  = bad_cur || (phase_cur == PH_MIN);
  assign flags.table_full = full;
  assign entry_index      = full ? INDEX_W'(ENT_W'(TABLE_ENTRIES - 1)) : INDEX_W'(entry_cur);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      minutes_acc  <= '0;
      seconds_acc  <= '0;
      fraction_acc <= '0;
      digit_count  <= '0;
      bad_tag      <= 1'b0;
      entry_count  <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      minutes_acc  <= minutes_acc_next;
      seconds_acc  <= seconds_acc_next;
      fraction_acc <= fraction_acc_next;
      digit_count  <= digit_count_next;
      bad_tag      <= bad_tag_next;
      entry_count  <= entry_count_next;
    end
  end

endmodule

/* hdl/lrcts_time_calc.sv */
// Three-stage pipeline turning captured tag fields into milliseconds.
module lrcts_time_calc #(
  parameter int FIELD_DIGITS = 3,
  parameter int ACC_W        = $clog2(10 ** FIELD_DIGITS),
  parameter int CNT_W        = $clog2(FIELD_DIGITS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tag_valid,
  output logic                          tag_ready,
  input  logic [ACC_W-1:0]              minutes,
  input  logic [ACC_W-1:0]              seconds,
  input  logic [ACC_W-1:0]              fraction,
  input  logic [CNT_W-1:0]              frac_digits,
  input  lrcts_pkg::tag_flags_t         flags,
  input  logic [lrcts_pkg::INDEX_W-1:0] entry_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lrcts_pkg::TIME_W-1:0]  time_ms,
  output logic [lrcts_pkg::INDEX_W-1:0] out_index,
  output lrcts_pkg::tag_flags_t         out_flags
);
  import lrcts_pkg::*;

  localparam int RECIP_W = ACC_W + 13;

  // capture stage
  logic               a_valid, a_ready;
  logic [ACC_W-1:0]   a_min, a_sec, a_frac;
  logic [CNT_W-1:0]   a_fdig;
  tag_flags_t         a_flags;
  logic [INDEX_W-1:0] a_idx;

  // product stage
  logic               b_valid, b_ready;
  logic [TIME_W-1:0]  b_min_ms, b_secfrac_ms;
  tag_flags_t         b_flags;
  logic [INDEX_W-1:0] b_idx;

  logic               c_ready;
  logic [TIME_W-1:0]  frac_ms;
  logic [RECIP_W-1:0] div_prod;

  assign c_ready   = !out_valid || out_ready;
  assign b_ready   = !b_valid || c_ready;
  assign a_ready   = !a_valid || b_ready;
  assign tag_ready = a_ready;

  assign div_prod = RECIP_W'(a_frac) * RECIP_W'(DIV10_RECIP);

  // scale the fraction by how many digits it carried
  always_comb begin
    case (a_fdig)
      CNT_W'(0): frac_ms = '0;
      CNT_W'(1): frac_ms = TIME_W'(a_frac) * TIME_W'(MS_PER_TENTH);
      CNT_W'(2): frac_ms = TIME_W'(a_frac) * TIME_W'(MS_PER_HUNDREDTH);
      CNT_W'(3): frac_ms = TIME_W'(a_frac);
      default:   frac_ms = TIME_W'(div_prod >> DIV10_SHIFT);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= tag_valid;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && tag_valid) begin
      a_min   <= minutes;
      a_sec   <= seconds;
      a_frac  <= fraction;
      a_fdig  <= frac_digits;
      a_flags <= flags;
      a_idx   <= entry_index;
    end
    if (b_ready && a_valid) begin
      b_min_ms     <= TIME_W'(a_min) * TIME_W'(MS_PER_MIN);
      b_secfrac_ms <= TIME_W'(a_sec) * TIME_W'(MS_PER_SEC) + frac_ms;
      b_flags      <= a_flags;
      b_idx        <= a_idx;
    end
    if (c_ready && b_valid) begin
      time_ms   <= b_min_ms + b_secfrac_ms;
      out_flags <= b_flags;
      out_index <= b_idx;
    end
  end

endmodule

/* hdl/lrcts_checker.sv */
// Port-level assertions for the LRC time-tag parser, bound to the top level.
module lrcts_checker #(
  parameter int TABLE_ENTRIES = 256
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [lrcts_pkg::TIME_W-1:0]  time_ms,
  input logic [lrcts_pkg::INDEX_W-1:0] entry_index,
  input logic                          malformed,
  input logic                          table_full
);
  import lrcts_pkg::*;

  localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(TABLE_ENTRIES - 1);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(time_ms) && $stable(entry_index)
      && $stable(malformed) && $stable(table_full))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // an empty output register means the pipeline can always take a byte
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_full_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> entry_index == LAST_INDEX)
    else $error("full table without saturated index");

endmodule

bind lrc_timestamp_tag_parser_top lrcts_checker #(
  .TABLE_ENTRIES(TABLE_ENTRIES)
) u_checker (.*);
